// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define TSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define TSS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/tss_pkg.sv -----
`default_nettype none
package tss_pkg;

  localparam int unsigned POS_W   = 15;
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned BIN_W   = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  // Angles in centidegrees.
  localparam logic [POS_W-1:0] HOME_CD    = 15'd9000;
  localparam logic [POS_W-1:0] ANGLE_45   = 15'd4500;
  localparam logic [POS_W-1:0] ANGLE_135  = 15'd13500;
  localparam logic [POS_W-1:0] FULL_SCALE = 15'd18000;
  localparam logic [POS_W-1:0] DEAD_BAND  = 15'd50;

  localparam logic [SPEED_W-1:0] SPEED_MIN   = 7'd1;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 7'd50;
  localparam logic [PULSE_W-1:0] PMIN_RESET  = 12'd150;
  localparam logic [PULSE_W-1:0] PMAX_RESET  = 12'd600;

  // Sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ROT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TILT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PMIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PMAX  = 2'd2;

  // Bin codes.
  localparam logic [BIN_W-1:0] BIN_1 = 3'd1;
  localparam logic [BIN_W-1:0] BIN_2 = 3'd2;
  localparam logic [BIN_W-1:0] BIN_3 = 3'd3;
  localparam logic [BIN_W-1:0] BIN_4 = 3'd4;

  // pos / 100 as (pos * 5243) >> 19, exact for every position up to full scale.
  localparam logic [12:0] DEG_RECIP = 13'd5243;
  localparam int unsigned DEG_SHIFT = 19;
  // x / 180 as (x * 745655) >> 27, exact for x below 2^27 / 172.
  localparam logic [19:0] SPAN_RECIP = 20'd745655;
  localparam int unsigned SPAN_SHIFT = 27;

  typedef struct packed {
    logic                 valid;
    logic [PHASE_W-1:0]   phase;
    logic                 done;
  } tss_tag_t;

  function automatic logic [POS_W-1:0] rot_target(input logic [BIN_W-1:0] b);
    case (b)
      BIN_1:   rot_target = ANGLE_45;
      BIN_2:   rot_target = ANGLE_135;
      BIN_3:   rot_target = ANGLE_45;
      BIN_4:   rot_target = ANGLE_135;
      default: rot_target = HOME_CD;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] tilt_target(input logic [BIN_W-1:0] b);
    case (b)
      BIN_1:   tilt_target = ANGLE_45;
      BIN_2:   tilt_target = ANGLE_45;
      BIN_3:   tilt_target = ANGLE_135;
      BIN_4:   tilt_target = ANGLE_135;
      default: tilt_target = HOME_CD;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tss_pulse.sv -----
`default_nettype none
module tss_pulse (
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic [tss_pkg::POS_W-1:0]   pos,
  input  wire logic [tss_pkg::PULSE_W-1:0] pulse_min,
  input  wire logic [tss_pkg::PULSE_W-1:0] pulse_max,
  output logic      [tss_pkg::PULSE_W-1:0] pulse
);
  import tss_pkg::*;

  logic [27:0]        deg_prod;
  logic [7:0]         deg_r, deg_nxt;
  logic [12:0]        span;
  logic signed [21:0] deg_s, span_s;
  logic signed [21:0] prod_r, prod_nxt;
  logic               neg;
  logic [21:0]        mag_full;
  logic [39:0]        q_prod;
  logic [PULSE_W-1:0] q;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;

  // Whole degrees of the position.
  always_comb begin
    deg_prod = 28'(pos) * 28'(DEG_RECIP);
    deg_nxt  = deg_prod[DEG_SHIFT+7:DEG_SHIFT];
  end

  // Signed product of degrees and pulse span.
  always_comb begin
    span     = {1'b0, pulse_max} - {1'b0, pulse_min};
    deg_s    = {14'd0, deg_r};
    span_s   = {{9{span[12]}}, span};
    prod_nxt = deg_s * span_s;
  end

  // Divide by 180 on the magnitude so the quotient truncates toward zero.
  always_comb begin
    neg       = prod_r[21];
    mag_full  = neg ? 22'(-prod_r) : 22'(prod_r);
    q_prod    = 40'(mag_full[19:0]) * 40'(SPAN_RECIP);
    q         = q_prod[SPAN_SHIFT+PULSE_W-1:SPAN_SHIFT];
    pulse_nxt = neg ? pulse_min - q : pulse_min + q;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r   <= deg_nxt;
      prod_r  <= prod_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  assign pulse = pulse_r;

endmodule
`default_nettype wire

// ----- rtl/tss_slew.sv -----
`default_nettype none
module tss_slew (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        adv,
  input  wire logic                        kind,
  input  wire logic [tss_pkg::BIN_W-1:0]   bin_select,
  input  wire logic [tss_pkg::SPEED_W-1:0] speed,
  output tss_pkg::tss_tag_t                tag,
  output logic      [tss_pkg::POS_W-1:0]   rot_pos,
  output logic      [tss_pkg::POS_W-1:0]   tilt_pos
);
  import tss_pkg::*;

  logic [POS_W-1:0]   rot_pos_r, rot_pos_nxt;
  logic [POS_W-1:0]   rot_goal_r;
  logic [POS_W-1:0]   tilt_pos_r, tilt_pos_nxt;
  logic [POS_W-1:0]   tilt_goal_r, tilt_goal_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BIN_W-1:0]   bin_r;
  logic [SPEED_W-1:0] sp;
  logic [7:0]         step;
  logic               done_nxt;

  tss_tag_t           tag_r, tag_nxt;
  logic [POS_W-1:0]   a_rot_r, a_tilt_r;

  function automatic logic moving(input logic [POS_W-1:0] p, input logic [POS_W-1:0] g);
    logic [POS_W-1:0] d;
    d = (p > g) ? p - g : g - p;
    moving = d > DEAD_BAND;
  endfunction

  function automatic logic [POS_W-1:0] slew(input logic [POS_W-1:0] p,
                                            input logic [POS_W-1:0] g,
                                            input logic [7:0]       st);
    logic [POS_W:0]   up;
    logic [POS_W-1:0] dn;
    logic [POS_W:0]   res;
    up  = {1'b0, p} + {8'd0, st};
    dn  = (p >= {7'd0, st}) ? p - {7'd0, st} : '0;
    res = {1'b0, p};
    if (moving(p, g)) begin
      if (p < g) begin
        res = (up > {1'b0, g}) ? {1'b0, g} : up;
      end else begin
        res = (dn < g) ? {1'b0, g} : {1'b0, dn};
      end
    end
    if (res > {1'b0, FULL_SCALE}) begin
      res = {1'b0, FULL_SCALE};
    end
    slew = res[POS_W-1:0];
  endfunction

  always_comb begin
    if (speed < SPEED_MIN) begin
      sp = SPEED_MIN;
    end else if (speed > SPEED_MAX) begin
      sp = SPEED_MAX;
    end else begin
      sp = speed;
    end
    step = {sp, 1'b0};
  end

  // One tick: move both joints, then advance the sequencer on the new positions.
  always_comb begin
    rot_pos_nxt   = slew(rot_pos_r, rot_goal_r, step);
    tilt_pos_nxt  = slew(tilt_pos_r, tilt_goal_r, step);
    tilt_goal_nxt = tilt_goal_r;
    phase_nxt     = PH_IDLE;
    case (phase_r)
      PH_ROT: begin
        phase_nxt = PH_ROT;
        if (!moving(rot_pos_nxt, rot_goal_r)) begin
          tilt_goal_nxt = tilt_target(bin_r);
          phase_nxt     = PH_TILT;
        end
      end
      PH_TILT: begin
        phase_nxt = moving(tilt_pos_nxt, tilt_goal_r) ? PH_TILT : PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
    done_nxt = !moving(rot_pos_nxt, rot_goal_r) && !moving(tilt_pos_nxt, tilt_goal_nxt)
               && (phase_nxt == PH_IDLE);
    tag_nxt.valid = accept && !kind;
    tag_nxt.phase = phase_nxt;
    tag_nxt.done  = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_pos_r   <= HOME_CD;
      rot_goal_r  <= HOME_CD;
      tilt_pos_r  <= HOME_CD;
      tilt_goal_r <= HOME_CD;
      phase_r     <= PH_IDLE;
      bin_r       <= '0;
    end else if (accept) begin
      if (kind) begin
        bin_r      <= bin_select;
        phase_r    <= PH_ROT;
        rot_goal_r <= rot_target(bin_select);
      end else begin
        rot_pos_r   <= rot_pos_nxt;
        tilt_pos_r  <= tilt_pos_nxt;
        tilt_goal_r <= tilt_goal_nxt;
        phase_r     <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rot_r  <= rot_pos_nxt;
      a_tilt_r <= tilt_pos_nxt;
    end
  end

  assign tag      = tag_r;
  assign rot_pos  = a_rot_r;
  assign tilt_pos = a_tilt_r;

endmodule
`default_nettype wire

// ----- rtl/two_axis_servo_slew_sequencer.sv -----
`default_nettype none
// Two-joint servo slew sequencer, rotation first and tilt second.
// Input channel (in_valid/in_ready): in_kind 1 starts a move to bin in_bin_select
// and yields no result word; in_kind 0 is one update tick and yields one word.
// Output channel (out_valid/out_ready): PWM counts of both joints after the tick,
// the sequencer phase and motion_done.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 speed code,
// 1 pulse_min, 2 pulse_max; other indexes are ignored. Write only while idle.
// Throughput: one word per cycle while the receiver does not stall. A tick passes
// four register stages before its word is presented on out_valid. The stages are
// the joint update, then the pulse scaling
// pipeline (degree multiply, span multiply, divide-by-180 multiply and add).
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_ready drops in the same cycle; nothing is dropped.
// Reset (rst_n low, synchronous) homes both joints at 90 degrees, goes idle,
// restores the register defaults and empties the pipeline.
module two_axis_servo_slew_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic [tss_pkg::BIN_W-1:0]     in_bin_select,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tss_pkg::PULSE_W-1:0]   out_rot_pulse,
  output logic      [tss_pkg::PULSE_W-1:0]   out_tilt_pulse,
  output logic      [tss_pkg::PHASE_W-1:0]   out_phase,
  output logic                               out_motion_done,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tss_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tss_pkg::*;

  logic               adv;
  logic               accept;
  logic [SPEED_W-1:0] speed_r;
  logic [PULSE_W-1:0] pmin_r, pmax_r;
  tss_tag_t           tag_a, tag_b_r, tag_c_r, tag_out_r;
  logic [POS_W-1:0]   rot_pos_a, tilt_pos_a;

  assign adv       = !tag_out_r.valid || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
      pmin_r  <= PMIN_RESET;
      pmax_r  <= PMAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED: speed_r <= cfg_data[SPEED_W-1:0];
        CFG_PMIN:  pmin_r  <= cfg_data[PULSE_W-1:0];
        CFG_PMAX:  pmax_r  <= cfg_data[PULSE_W-1:0];
        default:   ;
      endcase
    end
  end

  tss_slew u_slew (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .adv        (adv),
    .kind       (in_kind),
    .bin_select (in_bin_select),
    .speed      (speed_r),
    .tag        (tag_a),
    .rot_pos    (rot_pos_a),
    .tilt_pos   (tilt_pos_a)
  );

  tss_pulse u_rot_pulse (
    .clk       (clk),
    .adv       (adv),
    .pos       (rot_pos_a),
    .pulse_min (pmin_r),
    .pulse_max (pmax_r),
    .pulse     (out_rot_pulse)
  );

  tss_pulse u_tilt_pulse (
    .clk       (clk),
    .adv       (adv),
    .pos       (tilt_pos_a),
    .pulse_min (pmin_r),
    .pulse_max (pmax_r),
    .pulse     (out_tilt_pulse)
  );

  // Phase and done ride alongside the pulse pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r   <= '0;
      tag_c_r   <= '0;
      tag_out_r <= '0;
    end else if (adv) begin
      tag_b_r   <= tag_a;
      tag_c_r   <= tag_b_r;
      tag_out_r <= tag_c_r;
    end
  end

  assign out_valid       = tag_out_r.valid;
  assign out_phase       = tag_out_r.phase;
  assign out_motion_done = tag_out_r.done;

endmodule
`default_nettype wire

// ----- rtl/tss_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module tss_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_kind,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tss_pkg::PULSE_W-1:0] out_rot_pulse,
  input wire logic [tss_pkg::PHASE_W-1:0] out_phase,
  input wire logic                        out_motion_done
);
  import tss_pkg::*;

  // A stalled word holds its pulse value.
  `TSS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rot_pulse), "stalled result word changed")

  // The input side backs off while a result word is stuck.
  `TSS_ASSERT(a_backpressure, out_valid && !out_ready |-> !in_ready, "input accepted during output stall")

  // A tick with a free-running receiver comes out at the end of the pipeline.
  `TSS_ASSERT(a_latency, (in_valid && in_ready && !in_kind) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "tick result missing after pipeline latency")

  // Done is only reported when the sequence is idle.
  `TSS_ASSERT(a_done_idle, out_valid && out_motion_done |-> out_phase == PH_IDLE, "motion_done outside idle phase")

  // Reset empties the output register.
  `TSS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result word valid after reset")

endmodule

bind two_axis_servo_slew_sequencer tss_checker u_tss_checker (.*);
`default_nettype wire
